// File: sv/substring_search_from_position_top_defines.svh
// Assertion macros shared by the search block.
`ifndef SUBSTRING_SEARCH_FROM_POSITION_TOP_DEFINES_SVH
`define SUBSTRING_SEARCH_FROM_POSITION_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSFP_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SSFP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// File: sv/ssfp_pkg.sv
package ssfp_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int POS_W       = 16;
  localparam logic [POS_W-1:0] TEXT_MAX = 16'hFFFF;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS    = 8'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] match_start;
    logic             match_found;
  } out_t;

  // Control shared by every cell of the window chain.
  typedef struct packed {
    logic             shift_en;
    logic [LEN_W-1:0] len;
  } cell_ctrl_t;

  typedef logic [PATTERN_MAX-1:0][7:0] pattern_t;

endpackage

// File: sv/ssfp_cell.sv
// One window position: holds a text byte, passes it on to the next cell,
// and checks the byte it is about to take against its pattern byte.
module ssfp_cell (
  input  logic                       clk,
  input  ssfp_pkg::cell_ctrl_t       ctrl,
  input  logic [ssfp_pkg::IDX_W-1:0] cell_index,
  input  ssfp_pkg::pattern_t         pattern,
  input  logic [7:0]                 byte_in,
  output logic [7:0]                 byte_out,
  output logic                       hit
);

  logic [7:0]                 window_byte;
  logic [ssfp_pkg::LEN_W-1:0] pat_index;
  logic                       in_use;

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      window_byte <= byte_in;
    end
  end

  // Cell i lines up with pattern byte len-1-i once the new byte is in.
  assign in_use    = {1'b0, cell_index} < ctrl.len;
  assign pat_index = ctrl.len - ssfp_pkg::LEN_W'(1) - {1'b0, cell_index};
  assign hit       = !in_use || (byte_in == pattern[pat_index[ssfp_pkg::IDX_W-1:0]]);
  assign byte_out  = window_byte;

endmodule

// File: sv/substring_search_from_position_top.sv
// Streaming substring search with a 1-based start position.
// Text arrives on the input channel (in_valid, in_stall, in_data), one byte per
// request. A request with byte_present low carries no text; a request with
// end_of_text high closes the text and produces exactly one result on the
// output channel (out_valid, out_stall, out_data): the 1-based start of the
// first pattern match at or after start_position, or 0 when there is none.
// Other requests produce no result.
// Throughput is one request per cycle while in_stall is low. The byte window
// is a chain of sixteen cells, and all of them compare against the pattern in
// the same cycle the byte enters, so the whole check for one alignment
// happens in that cycle. out_valid rises in the cycle after the accepted
// end-of-text request. A single output register holds the result; while it
// is full and stalled, in_stall is raised, otherwise requests keep flowing.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// ready and should be issued only while the block is idle.
// Synchronous reset clears the pattern, sets start_position to 1, clears the
// byte count and any recorded match, and empties the output register.
`include "substring_search_from_position_top_defines.svh"

module substring_search_from_position_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ssfp_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ssfp_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ssfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int PM    = ssfp_pkg::PATTERN_MAX;
  localparam int POS_W = ssfp_pkg::POS_W;
  localparam int LEN_W = ssfp_pkg::LEN_W;

  // Configuration registers.
  logic [63:0]      pattern_bytes_low;
  logic [63:0]      pattern_bytes_high;
  logic [4:0]       pattern_length;
  logic [POS_W-1:0] start_position;

  // Text state.
  logic [POS_W-1:0] bytes_seen;
  logic             have_match;
  logic [POS_W-1:0] first_match_start;

  logic                 accept;
  logic                 count_en;
  logic [POS_W-1:0]     bytes_seen_next;
  logic                 have_match_next;
  logic [POS_W-1:0]     first_match_start_next;
  logic [LEN_W-1:0]     eff_len;
  logic [POS_W-1:0]     align_start;
  logic                 window_match;
  logic                 new_match;
  logic [POS_W-1:0]     result;
  ssfp_pkg::pattern_t   pattern;
  ssfp_pkg::cell_ctrl_t cell_ctrl;
  logic [PM-1:0][7:0]   chain_in;
  logic [PM-1:0][7:0]   chain_out;
  logic [PM-1:0]        cell_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
      pattern_length     <= '0;
      start_position     <= POS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssfp_pkg::CFG_PATTERN_LOW:  pattern_bytes_low  <= cfg_data;
        ssfp_pkg::CFG_PATTERN_HIGH: pattern_bytes_high <= cfg_data;
        ssfp_pkg::CFG_PATTERN_LEN:  pattern_length     <= cfg_data[4:0];
        ssfp_pkg::CFG_START_POS:    start_position     <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern = {pattern_bytes_high, pattern_bytes_low};

  // A length register above the window size acts as a full window.
  assign eff_len = (pattern_length > 5'(PM)) ? LEN_W'(PM) : LEN_W'(pattern_length);

  assign cell_ctrl.shift_en = accept && in_data.byte_present;
  assign cell_ctrl.len      = eff_len;

  // The newest byte enters cell 0; each cell hands its byte to the next.
  for (genvar i = 0; i < PM; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_in[i] = in_data.text_byte;
    end else begin : g_link
      assign chain_in[i] = chain_out[i-1];
    end
    ssfp_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .cell_index (ssfp_pkg::IDX_W'(i)),
      .pattern    (pattern),
      .byte_in    (chain_in[i]),
      .byte_out   (chain_out[i]),
      .hit        (cell_hit[i])
    );
  end

  assign window_match = &cell_hit;

  // Bytes past the count limit still shift the window but are not checked.
  assign count_en        = cell_ctrl.shift_en && (bytes_seen != ssfp_pkg::TEXT_MAX);
  assign bytes_seen_next = count_en ? bytes_seen + POS_W'(1) : bytes_seen;
  assign align_start     = bytes_seen_next - POS_W'(eff_len) + POS_W'(1);

  assign new_match = count_en && !have_match && (eff_len != '0)
                  && (bytes_seen_next >= POS_W'(eff_len))
                  && (start_position != '0) && (align_start >= start_position)
                  && window_match;

  assign have_match_next        = have_match || new_match;
  assign first_match_start_next = new_match ? align_start : first_match_start;

  // Result uses the state as it stands after this request's byte.
  always_comb begin
    result = '0;
    if ((start_position != '0) && (start_position <= bytes_seen_next)) begin
      if (eff_len == '0) begin
        result = start_position;
      end else if (have_match_next) begin
        result = first_match_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen        <= '0;
      have_match        <= 1'b0;
      first_match_start <= '0;
    end else if (accept) begin
      if (in_data.end_of_text) begin
        bytes_seen        <= '0;
        have_match        <= 1'b0;
        first_match_start <= '0;
      end else begin
        bytes_seen        <= bytes_seen_next;
        have_match        <= have_match_next;
        first_match_start <= first_match_start_next;
      end
    end
  end

  // Output register: loads when empty or when its result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= accept && in_data.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.end_of_text) begin
      out_data.match_start <= result;
      out_data.match_found <= result != '0;
    end
  end

  `SSFP_ASSERT_NOW(a_found_means_nonzero, out_valid && out_data.match_found, out_data.match_start != '0)
  `SSFP_ASSERT_NOW(a_match_start_nonzero, have_match, first_match_start != '0)
  `SSFP_ASSERT_NEXT(a_end_gives_result, accept && in_data.end_of_text, out_valid)
  `SSFP_ASSERT_NEXT(a_end_clears_text, accept && in_data.end_of_text, bytes_seen == '0 && !have_match)

endmodule

// File: test/tb.sv
// Testbench for the streaming substring search block.
//
// Text reaches the block one request at a time on the input channel. Every
// accepted request is also fed to a predictor that is kept inside this
// testbench. The predictor holds its own copy of the byte window, the byte
// count, the recorded match and the four configuration registers. When a
// request closes a text, the predictor queues the result it expects. The
// result checker takes each accepted output request and compares it, field by
// field, with the oldest queued expectation.
//
// Registers are written only while the block is idle. The testbench first
// waits until every queued result has arrived, and then waits out
// SETTLE_CYCLES so that the output register is sure to be empty.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no accepted request on any channel before the run is given up.
  localparam int QUIET_LIMIT = 3000;
  // Settling time after the last expected result. The block has a single
  // output register, so this is ample.
  localparam int SETTLE_CYCLES = 4;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  ssfp_pkg::in_t                  in_data;
  logic                           out_valid;
  logic                           out_stall;
  ssfp_pkg::out_t                 out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ssfp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                    cfg_data;

  substring_search_from_position_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the configuration registers.
  logic [63:0] shadow_pattern_low;
  logic [63:0] shadow_pattern_high;
  logic [4:0]  shadow_pattern_len;
  logic [15:0] shadow_start_pos;

  // Predictor copy of the per-text state. Entry 0 of the window is the newest
  // byte.
  logic [7:0] window_bytes [ssfp_pkg::PATTERN_MAX];
  int         text_count;
  bit         match_recorded;
  int         match_position;

  // Results that the predictor has worked out and that have not arrived yet.
  ssfp_pkg::out_t pending_matches [$];
  ssfp_pkg::out_t wanted_match;
  int             mismatches;

  // Stimulus controls. The idle rates are percentages per cycle.
  int send_idle_pct;
  int recv_idle_pct;
  int absent_pct;
  int hold_request;
  int hold_left;
  int quiet_cycles;

  // The text that the next call of send_text delivers, and the pattern that
  // the next call of load_pattern writes.
  logic [7:0] text_bytes [$];
  logic [7:0] pattern_bytes [ssfp_pkg::PATTERN_MAX];
  logic [7:0] alphabet [3];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clear the text state, as after reset and after every result.
  function automatic void clear_text_state();
    for (int k = 0; k < ssfp_pkg::PATTERN_MAX; k++) window_bytes[k] = 8'h00;
    text_count     = 0;
    match_recorded = 1'b0;
    match_position = 0;
  endfunction

  // Advance the predictor by one accepted request. A request that closes the
  // text queues the expected result.
  function automatic void predict_search(input ssfp_pkg::in_t req);
    int             len;
    int             align;
    int             answer;
    bit             same;
    logic [127:0]   pattern;
    ssfp_pkg::out_t res;
    pattern = {shadow_pattern_high, shadow_pattern_low};
    len = (shadow_pattern_len > ssfp_pkg::PATTERN_MAX) ? ssfp_pkg::PATTERN_MAX
                                                       : int'(shadow_pattern_len);
    if (req.byte_present) begin
      for (int k = ssfp_pkg::PATTERN_MAX - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
      window_bytes[0] = req.text_byte;
      // Once the count saturates, bytes still shift but are never compared.
      if (text_count < int'(ssfp_pkg::TEXT_MAX)) begin
        text_count++;
        if (!match_recorded && len > 0 && text_count >= len) begin
          align = text_count - len + 1;
          if (shadow_start_pos != 0 && align >= int'(shadow_start_pos)) begin
            same = 1'b1;
            for (int k = 0; k < len; k++) begin
              if (window_bytes[len-1-k] != pattern[8*k +: 8]) same = 1'b0;
            end
            if (same) begin
              match_recorded = 1'b1;
              match_position = align;
            end
          end
        end
      end
    end
    if (req.end_of_text) begin
      answer = 0;
      if (shadow_start_pos != 0 && int'(shadow_start_pos) <= text_count) begin
        if (len == 0) begin
          answer = int'(shadow_start_pos);
        end else if (match_recorded) begin
          answer = match_position;
        end
      end
      res.match_start = answer[15:0];
      res.match_found = (answer != 0);
      pending_matches.push_back(res);
      clear_text_state();
    end
  endfunction

  // Offer one request, idling first at the sender's rate, and hold it until
  // the block takes it. Called just after a rising edge, or at the start.
  task automatic send_request(input logic [7:0] data, input bit present, input bit last);
    ssfp_pkg::in_t req;
    req.text_byte    = data;
    req.byte_present = present;
    req.end_of_text  = last;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_search(req);
  endtask

  // Send the text held in text_bytes, with requests that carry no byte mixed
  // in. The text is closed either on its last byte or by a separate marker
  // request with no byte; an empty text is always closed by a marker.
  task automatic send_text(input bit separate_marker);
    int n;
    n = text_bytes.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < absent_pct) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      send_request(text_bytes[i], 1'b1, !separate_marker && i == n - 1);
    end
    if (separate_marker || n == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Stop sending and wait until every expected result has arrived and the
  // output stage has drained.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [ssfp_pkg::CFG_IDX_W-1:0] idx,
                                input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ssfp_pkg::CFG_PATTERN_LOW:  shadow_pattern_low  = value;
      ssfp_pkg::CFG_PATTERN_HIGH: shadow_pattern_high = value;
      ssfp_pkg::CFG_PATTERN_LEN:  shadow_pattern_len  = value[4:0];
      ssfp_pkg::CFG_START_POS:    shadow_start_pos    = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for the block to go idle, then write all four registers. The unused
  // upper bits of the length and start writes carry random values, which the
  // block must ignore.
  task automatic load_pattern(input logic [4:0] len, input logic [15:0] start);
    logic [63:0] low_word;
    logic [63:0] high_word;
    logic [63:0] filler;
    for (int k = 0; k < 8; k++) begin
      low_word[8*k +: 8]  = pattern_bytes[k];
      high_word[8*k +: 8] = pattern_bytes[k+8];
    end
    wait_idle();
    write_register(ssfp_pkg::CFG_PATTERN_LOW, low_word);
    write_register(ssfp_pkg::CFG_PATTERN_HIGH, high_word);
    filler = {$urandom, $urandom};
    write_register(ssfp_pkg::CFG_PATTERN_LEN, {filler[63:5], len});
    filler = {$urandom, $urandom};
    write_register(ssfp_pkg::CFG_START_POS, {filler[63:16], start});
  endtask

  // Right after reset the pattern is empty and the start is 1, so any text
  // with a byte gives 1, while an empty text gives 0.
  task automatic check_reset_defaults();
    text_bytes = '{8'h78, 8'h79};
    send_text(1'b1);
    text_bytes = {};
    send_text(1'b0);
  endtask

  // Byte extremes, the start position before and past a match, a zero start,
  // an empty pattern, and a length register above the window size.
  task automatic check_directed_cases();
    for (int k = 0; k < ssfp_pkg::PATTERN_MAX; k++) pattern_bytes[k] = 8'h00;
    pattern_bytes[0] = 8'hFF;
    load_pattern(5'd2, 16'd1);
    text_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF};
    send_text(1'b0);
    load_pattern(5'd2, 16'd3);
    send_text(1'b1);
    load_pattern(5'd2, 16'd0);
    text_bytes = '{8'hFF};
    send_text(1'b0);
    // An empty pattern returns the start position while it lies in the text.
    load_pattern(5'd0, 16'd3);
    text_bytes = '{8'h11, 8'h22, 8'h33};
    send_text(1'b0);
    // A length of 31 behaves like a full-width pattern of 16 bytes.
    for (int k = 0; k < ssfp_pkg::PATTERN_MAX; k++) pattern_bytes[k] = 8'($urandom_range(255));
    load_pattern(5'd31, 16'd1);
    text_bytes = {};
    for (int k = 0; k < ssfp_pkg::PATTERN_MAX; k++) text_bytes.push_back(pattern_bytes[k]);
    send_text(1'b0);
  endtask

  // Pick a pattern from a small alphabet so that partial matches are common.
  task automatic choose_random_config();
    int          pick;
    logic [4:0]  len;
    logic [15:0] start;
    alphabet[0] = 8'($urandom_range(255));
    alphabet[1] = 8'($urandom_range(255));
    alphabet[2] = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(255));
    if ($urandom_range(9) == 0) alphabet[0] = 8'h00;
    for (int k = 0; k < ssfp_pkg::PATTERN_MAX; k++) begin
      pattern_bytes[k] = ($urandom_range(99) < 85) ? alphabet[$urandom_range(2)]
                                                  : 8'($urandom_range(255));
    end
    // Now and then the pattern words take their extreme values.
    pick = $urandom_range(19);
    if (pick == 0) begin
      for (int k = 0; k < ssfp_pkg::PATTERN_MAX; k++) pattern_bytes[k] = 8'hFF;
    end else if (pick == 1) begin
      for (int k = 0; k < ssfp_pkg::PATTERN_MAX; k++) pattern_bytes[k] = 8'h00;
    end
    pick = $urandom_range(99);
    if (pick < 10)      len = 5'd0;
    else if (pick < 70) len = 5'($urandom_range(1, 4));
    else if (pick < 85) len = 5'($urandom_range(5, 15));
    else if (pick < 95) len = 5'd16;
    else                len = 5'($urandom_range(17, 31));
    pick = $urandom_range(99);
    if (pick < 45)      start = 16'd1;
    else if (pick < 75) start = 16'($urandom_range(0, 20));
    else if (pick < 85) start = 16'd0;
    else if (pick < 95) start = 16'($urandom_range(21, 65535));
    else                start = 16'hFFFF;
    load_pattern(len, start);
  endtask

  // Random texts in groups that share one configuration. Most texts contain
  // the pattern once or twice; the rest of their bytes come mostly from the
  // pattern's alphabet.
  task automatic check_random_texts(input int item_goal);
    int sent;
    int len;
    int eff;
    int spot;
    sent = 0;
    while (sent < item_goal) begin
      choose_random_config();
      eff = (shadow_pattern_len > ssfp_pkg::PATTERN_MAX) ? ssfp_pkg::PATTERN_MAX
                                                         : int'(shadow_pattern_len);
      repeat (4) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 40);
        text_bytes = {};
        for (int i = 0; i < len; i++) begin
          text_bytes.push_back(($urandom_range(99) < 75) ? alphabet[$urandom_range(2)]
                                                         : 8'($urandom_range(255)));
        end
        if (eff > 0 && len >= eff && $urandom_range(99) < 70) begin
          repeat ($urandom_range(1, 2)) begin
            spot = $urandom_range(0, len - eff);
            for (int k = 0; k < eff; k++) text_bytes[spot + k] = pattern_bytes[k];
          end
        end
        send_text($urandom_range(3) == 0);
        sent += len + 1;
      end
    end
  endtask

  // The receiver holds off long enough for the output register to fill and
  // the block to stall its input, while short texts keep being offered.
  task automatic check_output_hold();
    for (int k = 0; k < ssfp_pkg::PATTERN_MAX; k++) pattern_bytes[k] = 8'($urandom_range(255));
    load_pattern(5'd1, 16'd1);
    hold_request = 150;
    repeat (12) begin
      text_bytes = {};
      repeat ($urandom_range(1, 3)) begin
        text_bytes.push_back(($urandom_range(1) == 0) ? pattern_bytes[0]
                                                      : 8'($urandom_range(255)));
      end
      send_text(1'b0);
    end
  endtask

  // Receiver: stalls at its random rate, or for a whole hold-off stretch
  // when one has been requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request > 0) begin
        hold_left = hold_request - 1;
        hold_request = 0;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Result checker: each accepted result is matched against the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with none expected: match_start %0d match_found %0b",
                   out_data.match_start, out_data.match_found);
        end
      end else begin
        wanted_match = pending_matches.pop_front();
        if (out_data.match_start !== wanted_match.match_start ||
            out_data.match_found !== wanted_match.match_found) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected start %0d found %0b, got start %0d found %0b",
                     wanted_match.match_start, wanted_match.match_found,
                     out_data.match_start, out_data.match_found);
          end
        end
      end
    end
  end

  // Watchdog: the run is given up when no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    mismatches    = 0;
    hold_request  = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    absent_pct    = 8;
    send_idle_pct = 31;
    recv_idle_pct = 85;
    shadow_pattern_low  = '0;
    shadow_pattern_high = '0;
    shadow_pattern_len  = '0;
    shadow_start_pos    = 16'd1;
    clear_text_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_reset_defaults();
    check_directed_cases();
    check_random_texts(400);
    send_idle_pct = 85;
    recv_idle_pct = 31;
    check_random_texts(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    check_random_texts(400);
    check_output_hold();

    wait_idle();
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
